>>> rtl/gisa_pkg.sv
// Shared types and constants for the GPIO interrupt slot allocator.
`default_nettype none

package gisa_pkg;

    localparam int SLOT_MAX    = 8;
    localparam int SLOT_W      = 3;
    localparam int CNT_W       = 4;
    localparam int PIN_W       = 9;
    localparam int PIN_SEL_W   = 8;
    localparam int MODE_W      = 3;
    localparam int STAT_W      = 3;
    localparam int SELECT_BITS = 8;
    localparam int FILTER_BITS = 4;
    localparam int PIN_MAX     = 255;

    localparam logic [2:0]       FILTER_SET     = 3'h7;
    localparam logic [MODE_W-1:0] MODE_LAST     = 3'd3;
    localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 4'd8;

    // Register index carried by paddr[2]
    localparam logic REG_SLOT_COUNT = 1'b0;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_SET_POL = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_INVALID   = 3'd1,
        STAT_NO_RES    = 3'd2,
        STAT_EXISTS    = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE  = 2'd0,
        SEQ_SCAN  = 2'd1,
        SEQ_APPLY = 2'd2
    } seq_state_t;

    typedef struct packed {
        logic              free_found;
        logic [SLOT_W-1:0] free_idx;
        logic              match_found;
        logic [SLOT_W-1:0] match_idx;
    } scan_res_t;

endpackage

`default_nettype wire

>>> rtl/gisa_scan.sv
// Slot scanner: one slot per cycle through a shared pin comparator.
`default_nettype none

module gisa_scan (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic                             run,
    input  wire logic [gisa_pkg::CNT_W-1:0]       n_active,
    input  wire logic [gisa_pkg::PIN_W-1:0]       pin,
    input  wire logic                             entry_used,
    input  wire logic [gisa_pkg::PIN_SEL_W-1:0]   entry_pin,
    output logic      [gisa_pkg::CNT_W-1:0]       cnt,
    output logic                                  done,
    output gisa_pkg::scan_res_t                   res
);

    logic [gisa_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    gisa_pkg::scan_res_t        res_reg, res_next;
    logic                       hit;

    // Shared comparator: full-width pin against the stored 8-bit pin
    assign hit  = entry_used && ({1'b0, entry_pin} == pin);
    assign done = (cnt_reg >= n_active);
    assign cnt  = cnt_reg;
    assign res  = res_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        res_next = res_reg;
        if (start)
        begin
            cnt_next = '0;
            res_next = '0;
        end
        else if (run && !done)
        begin
            // Keep the lowest free slot and the lowest matching slot
            if (!entry_used && !res_reg.free_found)
            begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = cnt_reg[gisa_pkg::SLOT_W-1:0];
            end
            if (hit && !res_reg.match_found)
            begin
                res_next.match_found = 1'b1;
                res_next.match_idx   = cnt_reg[gisa_pkg::SLOT_W-1:0];
            end
            cnt_next = cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/gpio_irq_slot_allocator.sv
// Top level of the GPIO interrupt slot allocator: sequencer, slot table, ports.
// m_tvalid rises after the input transfer, the scan of N = min(slot_count, SLOTS) slots and
// the apply step, one item at a time; the slot scan visits one slot per cycle
// through a single shared pin comparator, and s_tready is low until the item is applied.
// A finished result waits in the output register while the next item is taken and scanned.
// Reset (rst_n low, asynchronous): all slots free, masks, select and filter fields zero,
// slot_count = 8, sequencer idle, no result pending.
`default_nettype none

module gpio_irq_slot_allocator #(
    parameter int SLOTS = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [1:0] op, [10:2] pin, [13:11] mode, [14] active_high, [15] pin_known,
    // [23:16] hw_pin_code
    input  wire logic [23:0]  s_tdata,
    // Result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [2:0] status, [5:3] slot, [13:6] edge_mask, [21:14] polarity_mask,
    // [53:22] select_lo, [85:54] select_hi, [117:86] filter_word,
    // [125:118] used_mask, [127:126] zero
    output logic      [127:0] m_tdata,
    // Configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [gisa_pkg::CNT_W-1:0] slot_count_reg;
    logic [gisa_pkg::CNT_W-1:0] n_active;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == gisa_pkg::REG_SLOT_COUNT) ? 32'(slot_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_count_reg <= gisa_pkg::SLOT_COUNT_RST;
        else if (psel && penable && pwrite && pready &&
                 paddr[2] == gisa_pkg::REG_SLOT_COUNT)
            slot_count_reg <= pwdata[gisa_pkg::CNT_W-1:0];
    end

    // Clamp the scanned range to the slots that exist
    assign n_active = (slot_count_reg > gisa_pkg::CNT_W'(SLOTS)) ?
                      gisa_pkg::CNT_W'(SLOTS) : slot_count_reg;

    // ------------------------------------------------------------------
    // Captured item
    // ------------------------------------------------------------------
    gisa_pkg::op_t                  op_reg;
    logic [gisa_pkg::PIN_W-1:0]     pin_reg;
    logic [gisa_pkg::MODE_W-1:0]    mode_reg;
    logic                           ah_reg;
    logic                           known_reg;
    logic [gisa_pkg::PIN_SEL_W-1:0] code_reg;
    logic                           in_fire;

    assign in_fire = s_tvalid && s_tready;

    // Payload holds from the input transfer until the item is applied
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= gisa_pkg::op_t'(s_tdata[1:0]);
            pin_reg   <= s_tdata[10:2];
            mode_reg  <= s_tdata[13:11];
            ah_reg    <= s_tdata[14];
            known_reg <= s_tdata[15];
            code_reg  <= s_tdata[23:16];
        end
    end

    // ------------------------------------------------------------------
    // Slot table
    // ------------------------------------------------------------------
    logic [SLOTS-1:0]                 slot_used_reg;
    logic [SLOTS-1:0]                 edge_reg;
    logic [SLOTS-1:0]                 pol_reg;
    logic [SLOTS-1:0]                 filt_reg;
    logic [gisa_pkg::PIN_SEL_W-1:0]   slot_pin_reg   [SLOTS];
    logic [gisa_pkg::PIN_SEL_W-1:0]   pin_select_reg [SLOTS];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    gisa_pkg::seq_state_t state_reg, state_next;
    logic                 out_valid_reg;
    gisa_pkg::status_t    status_reg;
    logic [gisa_pkg::SLOT_W-1:0] slot_reg;
    logic                 apply_fire;
    logic                 scan_start;
    logic                 scan_run;
    logic                 scan_done;
    logic [gisa_pkg::CNT_W-1:0] scan_cnt;
    logic [IDX_W-1:0]     scan_idx;
    gisa_pkg::scan_res_t  scan_res;

    assign scan_start = in_fire;
    assign scan_run   = (state_reg == gisa_pkg::SEQ_SCAN);
    assign apply_fire = (state_reg == gisa_pkg::SEQ_APPLY) && (!out_valid_reg || m_tready);
    assign s_tready   = (state_reg == gisa_pkg::SEQ_IDLE);
    assign scan_idx   = scan_cnt[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gisa_pkg::SEQ_IDLE:
            begin
                if (in_fire)
                    state_next = gisa_pkg::SEQ_SCAN;
            end
            gisa_pkg::SEQ_SCAN:
            begin
                if (scan_done)
                    state_next = gisa_pkg::SEQ_APPLY;
            end
            gisa_pkg::SEQ_APPLY:
            begin
                // Hold until the previous result has left the output register
                if (apply_fire)
                    state_next = gisa_pkg::SEQ_IDLE;
            end
            default:
                state_next = gisa_pkg::SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gisa_pkg::SEQ_IDLE;
        else
            state_reg <= state_next;
    end

    gisa_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .run        (scan_run),
        .n_active   (n_active),
        .pin        (pin_reg),
        .entry_used (slot_used_reg[scan_idx]),
        .entry_pin  (slot_pin_reg[scan_idx]),
        .cnt        (scan_cnt),
        .done       (scan_done),
        .res        (scan_res)
    );

    // ------------------------------------------------------------------
    // Apply decision from the scan result
    // ------------------------------------------------------------------
    gisa_pkg::status_t           stat;
    logic [gisa_pkg::SLOT_W-1:0] res_slot;
    logic [gisa_pkg::SLOT_W-1:0] tgt;
    logic [IDX_W-1:0]            tgt_idx;
    logic                        wr_sel;
    logic                        wr_alloc;
    logic                        wr_release;
    logic                        wr_pol;
    logic                        pin_bad;

    assign pin_bad = (pin_reg > gisa_pkg::PIN_W'(gisa_pkg::PIN_MAX));
    assign tgt_idx = tgt[IDX_W-1:0];

    always_comb
    begin
        stat       = gisa_pkg::STAT_INVALID;
        res_slot   = '0;
        tgt        = scan_res.match_idx;
        wr_sel     = 1'b0;
        wr_alloc   = 1'b0;
        wr_release = 1'b0;
        wr_pol     = 1'b0;
        unique case (op_reg)
            gisa_pkg::OP_ALLOC:
            begin
                // Range, then free slot, then duplicate, then table hit, then mode
                tgt = scan_res.free_idx;
                if (pin_bad)
                    stat = gisa_pkg::STAT_INVALID;
                else if (!scan_res.free_found)
                    stat = gisa_pkg::STAT_NO_RES;
                else if (scan_res.match_found)
                    stat = gisa_pkg::STAT_EXISTS;
                else if (!known_reg)
                    stat = gisa_pkg::STAT_NOT_FOUND;
                else
                begin
                    // The select field is written even when the mode is then refused
                    wr_sel = 1'b1;
                    if (mode_reg > gisa_pkg::MODE_LAST)
                        stat = gisa_pkg::STAT_INVALID;
                    else
                    begin
                        wr_alloc = 1'b1;
                        stat     = gisa_pkg::STAT_OK;
                        res_slot = scan_res.free_idx;
                    end
                end
            end
            gisa_pkg::OP_RELEASE:
            begin
                // No range check: an out-of-range pin never matches
                if (scan_res.match_found)
                begin
                    wr_release = 1'b1;
                    stat       = gisa_pkg::STAT_OK;
                    res_slot   = scan_res.match_idx;
                end
                else
                    stat = gisa_pkg::STAT_NOT_FOUND;
            end
            gisa_pkg::OP_SET_POL:
            begin
                if (pin_bad)
                    stat = gisa_pkg::STAT_INVALID;
                else if (scan_res.match_found)
                begin
                    wr_pol   = 1'b1;
                    stat     = gisa_pkg::STAT_OK;
                    res_slot = scan_res.match_idx;
                end
                else
                    stat = gisa_pkg::STAT_NOT_FOUND;
            end
            default:
                stat = gisa_pkg::STAT_INVALID;
        endcase
    end

    // Slot table update, one slot per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used_reg <= '0;
            edge_reg      <= '0;
            pol_reg       <= '0;
            filt_reg      <= '0;
            for (int i = 0; i < SLOTS; i++)
                pin_select_reg[i] <= '0;
        end
        else if (apply_fire)
        begin
            if (wr_sel)
                pin_select_reg[tgt_idx] <= code_reg;
            if (wr_alloc)
            begin
                slot_used_reg[tgt_idx] <= 1'b1;
                edge_reg[tgt_idx]      <= ~mode_reg[1];
                pol_reg[tgt_idx]       <= mode_reg[0];
                filt_reg[tgt_idx]      <= 1'b1;
            end
            if (wr_release)
                slot_used_reg[tgt_idx] <= 1'b0;
            if (wr_pol)
                pol_reg[tgt_idx] <= ~ah_reg;
        end
    end

    // Stored pin is read only while the slot is in use
    always_ff @(posedge clk)
    begin
        if (apply_fire && wr_alloc)
            slot_pin_reg[tgt_idx] <= pin_reg[gisa_pkg::PIN_SEL_W-1:0];
    end

    // ------------------------------------------------------------------
    // Result register; table fields are read live, since the table only
    // changes at the edge that reloads this register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (apply_fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (apply_fire)
        begin
            status_reg <= stat;
            slot_reg   <= res_slot;
        end
    end

    logic [gisa_pkg::SLOT_MAX*gisa_pkg::SELECT_BITS-1:0] sel_flat;
    logic [gisa_pkg::SLOT_MAX*gisa_pkg::FILTER_BITS-1:0] filt_flat;

    for (genvar i = 0; i < gisa_pkg::SLOT_MAX; i++)
    begin : g_pack
        if (i < SLOTS)
        begin : g_live
            assign sel_flat[i*gisa_pkg::SELECT_BITS +: gisa_pkg::SELECT_BITS] =
                pin_select_reg[i];
            assign filt_flat[i*gisa_pkg::FILTER_BITS +: gisa_pkg::FILTER_BITS] =
                {1'b0, gisa_pkg::FILTER_SET & {3{filt_reg[i]}}};
        end
        else
        begin : g_absent
            assign sel_flat[i*gisa_pkg::SELECT_BITS +: gisa_pkg::SELECT_BITS]  = '0;
            assign filt_flat[i*gisa_pkg::FILTER_BITS +: gisa_pkg::FILTER_BITS] = '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       8'(slot_used_reg),
                       filt_flat,
                       sel_flat[63:32],
                       sel_flat[31:0],
                       8'(pol_reg),
                       8'(edge_reg),
                       slot_reg,
                       status_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == gisa_pkg::SEQ_SCAN)
        else $error("accepted item did not start a scan");

    a_used_only_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
        !apply_fire |=> $stable(slot_used_reg))
        else $error("slot use changed outside an apply");

    a_alloc_target_free: assert property (@(posedge clk) disable iff (!rst_n)
        (apply_fire && wr_alloc) |-> !slot_used_reg[tgt_idx])
        else $error("allocation targets a slot in use");

    a_apply_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gisa_pkg::SEQ_APPLY) |-> scan_done)
        else $error("apply reached before scan finished");

    a_apply_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        apply_fire |=> m_tvalid)
        else $error("applied item produced no result");

endmodule

`default_nettype wire
